>>> src/radix_to_ascii_converter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for radix_to_ascii_converter
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RADIX_TO_ASCII_CONVERTER_ASSERT_SVH
`define RADIX_TO_ASCII_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define RTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RTA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rta_pkg.sv
// ----------------------------------------------------------------------------
// rta_pkg
// Types, constants and microcode for the radix to ASCII converter.
// ----------------------------------------------------------------------------
package rta_pkg;

  localparam int unsigned MAX_DIGITS = 64;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned PTR_W      = 6;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BITS_PER_STEP = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [DIGIT_W-1:0] DEC_MAX   = 4'd9;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 7'h61;  // 'a'
  localparam logic [CHAR_W-1:0]  TEN          = 7'd10;

  // Program steps.
  typedef enum logic [2:0] {
    S_IDLE,   // wait for input, load operands
    S_DIV,    // divide 8 bits per cycle
    S_STORE,  // store remainder as digit
    S_READ,   // read digit store
    S_SEND,   // present character
    S_ADV     // step to next digit or finish
  } step_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_CHUNK_LAST,
    COND_MORE_DIGITS,
    COND_OUT_TAKEN,
    COND_PTR_ZERO
  } cond_e;

  typedef struct packed {
    step_e jmp_t;      // target when condition holds
    step_e jmp_f;      // target otherwise
    cond_e cond;
    logic  in_ready;
    logic  load;
    logic  div;
    logic  store;
    logic  read;
    logic  out_valid;
    logic  dec;
  } ctrl_t;

  // Microcode table.
  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    w = '{jmp_t: S_IDLE, jmp_f: S_IDLE, cond: COND_ALWAYS, default: 1'b0};
    unique case (s)
      S_IDLE: begin
        w.jmp_t = S_DIV;   w.jmp_f = S_IDLE;  w.cond = COND_IN_VALID;
        w.in_ready = 1'b1; w.load = 1'b1;
      end
      S_DIV: begin
        w.jmp_t = S_STORE; w.jmp_f = S_DIV;   w.cond = COND_CHUNK_LAST;
        w.div = 1'b1;
      end
      S_STORE: begin
        w.jmp_t = S_DIV;   w.jmp_f = S_READ;  w.cond = COND_MORE_DIGITS;
        w.store = 1'b1;
      end
      S_READ: begin
        w.jmp_t = S_SEND;  w.jmp_f = S_SEND;  w.cond = COND_ALWAYS;
        w.read = 1'b1;
      end
      S_SEND: begin
        w.jmp_t = S_ADV;   w.jmp_f = S_SEND;  w.cond = COND_OUT_TAKEN;
        w.out_valid = 1'b1;
      end
      S_ADV: begin
        w.jmp_t = S_IDLE;  w.jmp_f = S_READ;  w.cond = COND_PTR_ZERO;
        w.dec = 1'b1;
      end
      default: begin
        w.jmp_t = S_IDLE;  w.jmp_f = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // ASCII code of one digit.
  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d, logic upper);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d > DEC_MAX) begin
      return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + dx - TEN;
    end
    return CHAR_ZERO + dx;
  endfunction

endpackage

>>> src/radix_to_ascii_converter.sv
// ----------------------------------------------------------------------------
// radix_to_ascii_converter
// Emits the ASCII digits of an unsigned value in base 2..16, MSB digit first.
// ----------------------------------------------------------------------------
// Sequence: a load step, then per digit the divider walks CHUNKS chunks (CHUNKS =
//   ceil(VALUE_BITS/8), the divider takes 8 quotient bits a cycle) and a store step,
//   then a read, send and advance step per character out. One value at a time: a new
//   value is taken only after the last character of the previous one has been sent.
// Reset: asynchronous, active low; clears the sequencer and counters. The digit
//   store is not cleared: every entry is written before it is read.
module radix_to_ascii_converter #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [63:0] value, [68:64] radix, [69] upper_case, [71:70] zero
  input  logic [71:0] s_axis_tdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [6:0] character, [7] zero
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i
);

  // Divider geometry: value padded to whole 8-bit chunks.
  localparam int unsigned STEP    = rta_pkg::BITS_PER_STEP;
  localparam int unsigned CHUNKS  = (VALUE_BITS + STEP - 1) / STEP;
  localparam int unsigned PAD     = CHUNKS * STEP;
  localparam int unsigned CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  // Sequencer
  rta_pkg::step_e step_q, step_d;
  rta_pkg::ctrl_t ctrl;
  logic           cond_hit;

  // Datapath registers
  logic [PAD-1:0]                    work_q;     // dividend, then quotient
  logic [rta_pkg::DIGIT_W-1:0]       rem_q;      // running remainder
  logic [rta_pkg::RADIX_W-1:0]       radix_q;
  logic                              upper_q;
  logic [CHUNK_W-1:0]                chunk_q;
  logic [rta_pkg::COUNT_W-1:0]       count_q;
  logic [rta_pkg::PTR_W-1:0]         ptr_q;      // read pointer, counts down
  logic [rta_pkg::DIGIT_W-1:0]       rdata_q;

  // Digit store, least significant digit at entry 0
  logic [rta_pkg::DIGIT_W-1:0] digit_mem [rta_pkg::MAX_DIGITS];

  // Input unpacking with base saturation
  logic [rta_pkg::RADIX_W-1:0] radix_in, radix_sat;
  assign radix_in = s_axis_tdata_i[68:64];

  always_comb begin
    priority if (radix_in < rta_pkg::RADIX_MIN) begin
      radix_sat = rta_pkg::RADIX_MIN;
    end else if (radix_in > rta_pkg::RADIX_MAX) begin
      radix_sat = rta_pkg::RADIX_MAX;
    end else begin
      radix_sat = radix_in;
    end
  end

  // One divider step: restoring division of the top 8 bits by the base.
  // Remainder stays below the base, so 4 bits hold it.
  logic [STEP-1:0]             qbits;
  logic [rta_pkg::DIGIT_W-1:0] rem_div;

  always_comb begin
    logic [rta_pkg::RADIX_W-1:0] r;
    logic [rta_pkg::DIGIT_W-1:0] rr;
    rr = rem_q;
    qbits = '0;
    for (int i = 0; i < STEP; i++) begin
      r = {rr, work_q[PAD-1-i]};
      if (r >= radix_q) begin
        qbits[STEP-1-i] = 1'b1;
        r = r - radix_q;
      end
      rr = r[rta_pkg::DIGIT_W-1:0];
    end
    rem_div = rr;
  end

  // Jump condition select
  always_comb begin
    unique case (ctrl.cond)
      rta_pkg::COND_ALWAYS:      cond_hit = 1'b1;
      rta_pkg::COND_IN_VALID:    cond_hit = s_axis_tvalid_i;
      rta_pkg::COND_CHUNK_LAST:  cond_hit = (chunk_q == CHUNK_W'(CHUNKS - 1));
      // Count increments this cycle; stop at the store depth.
      rta_pkg::COND_MORE_DIGITS: cond_hit = (work_q != '0) &&
          (count_q < rta_pkg::COUNT_W'(rta_pkg::MAX_DIGITS - 1));
      rta_pkg::COND_OUT_TAKEN:   cond_hit = m_axis_tready_i;
      rta_pkg::COND_PTR_ZERO:    cond_hit = (ptr_q == '0);
      default:                   cond_hit = 1'b1;
    endcase
  end

  // Next step from the control word
  always_comb begin
    ctrl   = rta_pkg::ucode(step_q);
    step_d = cond_hit ? ctrl.jmp_t : ctrl.jmp_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= rta_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      chunk_q <= '0;
    end else begin
      if (ctrl.load && s_axis_tvalid_i) begin
        count_q <= '0;
        chunk_q <= '0;
      end else if (ctrl.div) begin
        chunk_q <= chunk_q + CHUNK_W'(1);
      end else if (ctrl.store) begin
        count_q <= count_q + rta_pkg::COUNT_W'(1);
        chunk_q <= '0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (ctrl.load && s_axis_tvalid_i) begin
      work_q  <= PAD'(s_axis_tdata_i[VALUE_BITS-1:0]);
      rem_q   <= '0;
      radix_q <= radix_sat;
      upper_q <= s_axis_tdata_i[69];
    end
    if (ctrl.div) begin
      work_q <= (work_q << STEP) | PAD'(qbits);
      rem_q  <= rem_div;
    end
    if (ctrl.store) begin
      digit_mem[count_q[rta_pkg::PTR_W-1:0]] <= rem_q;
      rem_q <= '0;
      ptr_q <= count_q[rta_pkg::PTR_W-1:0];  // last stored entry
    end
    if (ctrl.read) begin
      rdata_q <= digit_mem[ptr_q];
    end
    if (ctrl.dec && (ptr_q != '0)) begin
      ptr_q <= ptr_q - rta_pkg::PTR_W'(1);
    end
  end

  // Ports
  assign s_axis_tready_o = ctrl.in_ready;
  assign m_axis_tvalid_o = ctrl.out_valid;
  assign m_axis_tdata_o  = {1'b0, rta_pkg::digit_char(rdata_q, upper_q)};
  assign m_axis_tlast_o  = (ptr_q == '0);

  // Checks
  localparam logic [rta_pkg::COUNT_W-1:0] COUNT_LIM = rta_pkg::COUNT_W'(rta_pkg::MAX_DIGITS);

  // Final character transfer of a value
  logic last_xfer;
  assign last_xfer = m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o;

  `include "radix_to_ascii_converter_assert.svh"

  `RTA_ASSERT_IMP(a_one_item, m_axis_tvalid_o, !s_axis_tready_o, "input taken while sending")
  `RTA_ASSERT_IMP(a_count_max, 1'b1, count_q <= COUNT_LIM, "digit count overflow")
  `RTA_ASSERT_NXT(a_last_ends, last_xfer, !m_axis_tvalid_o, "output after last transfer")

endmodule

>>> tb/radix_to_ascii_checker.sv
// ----------------------------------------------------------------------------
// radix_to_ascii_checker
// Watches both stream channels of the converter, works out the digit string of
// every accepted value and compares each character transfer against it.
// ----------------------------------------------------------------------------
module radix_to_ascii_checker #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [71:0] s_tdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  m_tdata_i,
  input  logic        m_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  output int          errors_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0]                VALUE_MASK  = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam logic [rta_pkg::CHAR_W-1:0] ASC_ZERO    = 7'h30;
  localparam logic [rta_pkg::CHAR_W-1:0] ASC_UPPER_A = 7'h41;
  localparam logic [rta_pkg::CHAR_W-1:0] ASC_LOWER_A = 7'h61;

  typedef struct packed {
    logic [rta_pkg::CHAR_W-1:0] code;
    logic                       last;
  } digit_char_t;

  digit_char_t expected_chars[$];
  digit_char_t oldest;
  int          mismatches = 0;
  int          pending    = 0;

  assign errors_o  = mismatches;
  assign pending_o = pending;

  // Digit string of one value, most significant digit first.
  function automatic void spell_value(input logic [63:0] value,
                                      input logic [rta_pkg::RADIX_W-1:0] radix,
                                      input logic upper);
    logic [63:0]                 base;
    logic [63:0]                 rest;
    logic [rta_pkg::DIGIT_W-1:0] digits [rta_pkg::MAX_DIGITS];
    int                          n;
    digit_char_t                 c;
    // out-of-range bases saturate
    if (radix < 5'd2) base = 64'd2;
    else if (radix > 5'd16) base = 64'd16;
    else base = 64'(radix);
    rest = value & VALUE_MASK;
    n = 0;
    do begin
      digits[n] = rta_pkg::DIGIT_W'(rest % base);
      n++;
      rest = rest / base;
    end while (rest != 0 && n < rta_pkg::MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      if (digits[k] > 4'd9) begin
        c.code = (upper ? ASC_UPPER_A : ASC_LOWER_A) +
                 rta_pkg::CHAR_W'(digits[k]) - 7'd10;
      end else begin
        c.code = ASC_ZERO + rta_pkg::CHAR_W'(digits[k]);
      end
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 100) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_chars.delete();
      pending <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        spell_value(s_tdata_i[63:0], s_tdata_i[64 +: rta_pkg::RADIX_W],
                    s_tdata_i[64 + rta_pkg::RADIX_W]);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          $error("character transfer 0x%0h with nothing expected", m_tdata_i);
        end else begin
          oldest = expected_chars.pop_front();
          check_field("character", oldest.code, m_tdata_i[rta_pkg::CHAR_W-1:0]);
          check_field("last", oldest.last, m_tlast_i);
          check_field("tdata pad", 0, m_tdata_i[7]);
        end
      end
      pending <= expected_chars.size();
    end
  end

endmodule

>>> tb/tb_radix_to_ascii_converter.sv
// ----------------------------------------------------------------------------
// tb_radix_to_ascii_converter
// Feeds values, bases and case flags into the converter with bursty input and
// a stalling sink; the checker beside the block compares every character.
// ----------------------------------------------------------------------------
module tb_radix_to_ascii_converter;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_BITS  = 64;
  localparam int          HOLD_CYCLES = 300;   // long sink hold-off
  localparam int          IDLE_LIMIT  = 4000;  // cycles with no transfer at all
  localparam int          RANDOM_VALUES = 140;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  // tdata: [63:0] value, [68:64] radix, [69] upper_case, [71:70] zero
  logic [71:0] s_axis_tdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // tdata: [6:0] character, [7] zero
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;

  logic        hold_req = 1'b0;   // asks the sink process for one long hold-off
  int          errors;
  int          pending;
  int          burst_left = 0;
  int          quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  radix_to_ascii_converter #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  radix_to_ascii_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tdata_i (s_axis_tdata_i),
    .s_tvalid_i(s_axis_tvalid_i),
    .s_tready_i(s_axis_tready_o),
    .m_tdata_i (m_axis_tdata_o),
    .m_tlast_i (m_axis_tlast_o),
    .m_tvalid_i(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .errors_o  (errors),
    .pending_o (pending)
  );

  // Offer one value at the falling edge and hold it until the block takes it.
  // tvalid stays high across back-to-back transfers.
  task automatic offer_value(input logic [63:0] value, input logic [4:0] radix,
                             input logic upper);
    @(negedge clk_i);
    s_axis_tdata_i  = {2'b00, upper, radix, value};
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Drop tvalid for the given number of cycles.
  task automatic idle_sender(input int cycles);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Bursts of random length, random gaps between them. Gap lengths span the
  // load, divide and output phases of a conversion.
  task automatic pace_sender();
    if (burst_left == 0) begin
      idle_sender($urandom_range(1, 60));
      burst_left = $urandom_range(1, 6);
    end
    burst_left--;
  endtask

  // Sink: runs of always-ready, mostly-ready and mostly-stalled, plus one
  // long hold-off on request, counted here.
  initial begin
    int   run_left;
    int   mode;
    logic held;
    run_left = 0;
    mode     = 0;
    held     = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        m_axis_tready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        held = 1'b1;
      end
      if (run_left == 0) begin
        mode     = $urandom_range(0, 2);
        run_left = $urandom_range(8, 80);
      end
      run_left--;
      case (mode)
        0:       m_axis_tready_i = 1'b1;
        1:       m_axis_tready_i = ($urandom_range(0, 3) != 0);
        default: m_axis_tready_i = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Watchdog: a stretch with no transfer on either channel ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] value;
    logic [4:0]  radix;
    logic        upper;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, back to back: zero, extremes, every base, both cases,
    // saturated bases.
    offer_value(64'd0, 5'd10, 1'b0);
    offer_value(64'd0, 5'd0, 1'b1);
    offer_value(64'd1, 5'd2, 1'b0);
    offer_value({64{1'b1}}, 5'd2, 1'b1);
    offer_value(64'h8000_0000_0000_0000, 5'd2, 1'b0);
    offer_value({64{1'b1}}, 5'd16, 1'b1);
    offer_value({64{1'b1}}, 5'd16, 1'b0);
    offer_value({64{1'b1}}, 5'd10, 1'b0);
    offer_value(64'h0123_4567_89AB_CDEF, 5'd16, 1'b1);
    offer_value(64'hFEDC_BA98_7654_3210, 5'd16, 1'b0);
    offer_value(64'd255, 5'd0, 1'b0);       // base below two
    offer_value(64'd255, 5'd1, 1'b1);
    offer_value(64'hABCD, 5'd17, 1'b1);     // base above sixteen
    offer_value(64'hABCD, 5'd31, 1'b0);
    for (int b = 3; b <= 15; b++) begin
      offer_value(64'h5555_AAAA_3C3C_C3C3, 5'(b), b[0]);
    end
    offer_value(64'd12, 5'd12, 1'b0);       // reads "10"
    offer_value(64'd14, 5'd15, 1'b1);       // single high digit

    // Random part.
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      case ($urandom_range(0, 3))
        0:       value = 64'($urandom_range(0, 300));
        1:       value = {$urandom, $urandom} >> $urandom_range(0, 63);
        default: value = {$urandom, $urandom};
      endcase
      if ($urandom_range(0, 9) == 0) radix = 5'($urandom_range(0, 31));
      else radix = 5'($urandom_range(2, 16));
      upper = 1'($urandom_range(0, 1));

      // Sink holds off while values keep coming: the block fills and stalls.
      if (i == 60) hold_req = 1'b1;
      // Sender waits for every character before going on.
      if (i == 110) begin
        idle_sender(1);
        while (pending != 0) @(posedge clk_i);
      end
      // First stretch of the random part runs without input gaps.
      if (i >= 30) pace_sender();
      offer_value(value, radix, upper);
    end

    idle_sender(1);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
